### rtl/core/flha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flha_pkg
// Shared types and constants for the fault-line heightmap accumulator:
// item structs, operation codes, command queue entry and back-end states.
// ----------------------------------------------------------------------------
package flha_pkg;

  localparam int HEIGHT_W    = 16;
  localparam int SIDE_W      = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 16'sh7FFF;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 16'sh8000;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_ONE = 16'sd1;

  localparam logic [SIDE_W-1:0] ACTIVE_SIDE_RESET = 9'd256;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FAULT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic        [1:0]  operation;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_z;
    logic signed [23:0] line_offset;
    logic        [7:0]  cell_x;
    logic        [7:0]  cell_z;
  } flha_in_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] cell_height;
    logic signed [HEIGHT_W-1:0] highest;
    logic signed [HEIGHT_W-1:0] lowest;
  } flha_out_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_FAULT,
    CMD_READ,
    CMD_NONE
  } flha_kind_t;

  typedef struct packed {
    flha_kind_t         kind;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_z;
    logic signed [23:0] line_offset;
    logic        [7:0]  cell_x;
    logic        [7:0]  cell_z;
    logic               in_grid;
  } flha_cmd_t;

  typedef struct packed {
    logic pop;
    logic init_done;
  } flha_stat_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_FAULT,
    S_DRAIN,
    S_READ,
    S_RDATA,
    S_DONE
  } flha_state_t;

endpackage
`default_nettype wire

### rtl/core/flha_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flha_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module flha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/flha_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flha_front
// Input side: accepts items, classifies the operation, checks the read
// coordinates against the grid and queues commands for the back end.
// ----------------------------------------------------------------------------
module flha_front
  import flha_pkg::*;
#(
  parameter int GRID_SIDE = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire flha_in_t   in_data,
  output logic            cmd_valid,
  output flha_cmd_t       cmd,
  input  wire flha_stat_t stat
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  flha_cmd_t        q_r [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push;
  logic             pop;
  flha_cmd_t        new_cmd;

  assign in_ready  = stat.init_done && (cnt_r != QCW'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign pop       = stat.pop && cmd_valid;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.dir_x       = in_data.dir_x;
    new_cmd.dir_z       = in_data.dir_z;
    new_cmd.line_offset = in_data.line_offset;
    new_cmd.cell_x      = in_data.cell_x;
    new_cmd.cell_z      = in_data.cell_z;
    new_cmd.in_grid     = (32'(in_data.cell_x) < GRID_SIDE) &&
                          (32'(in_data.cell_z) < GRID_SIDE);
    case (in_data.operation)
      OP_CLEAR: new_cmd.kind = CMD_CLEAR;
      OP_FAULT: new_cmd.kind = CMD_FAULT;
      OP_READ:  new_cmd.kind = CMD_READ;
      default:  new_cmd.kind = CMD_NONE;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QPW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/core/flha_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flha_back
// Execution side: clearing sweep, fault sweep with a one-cell-per-cycle
// read-modify-write pipeline, single cell reads, marks and result register.
// ----------------------------------------------------------------------------
module flha_back
  import flha_pkg::*;
#(
  parameter int GRID_SIDE = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SIDE_W-1:0] active_side,
  input  wire logic              cmd_valid,
  input  wire flha_cmd_t         cmd,
  output flha_stat_t             stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output flha_out_t              out_data
);

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = $clog2(GRID_SIDE + 1);
  localparam int TW_MIN = 16 + SW + 2;
  localparam int TW     = (TW_MIN > 26) ? TW_MIN : 26;

  flha_state_t state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        wb_valid_r, wb_valid_nxt;
  logic [AW-1:0]               clr_addr_r, clr_addr_nxt;
  logic signed [HEIGHT_W-1:0]  high_r, high_nxt;
  logic signed [HEIGHT_W-1:0]  low_r, low_nxt;

  flha_cmd_t                   cmd_r, cmd_nxt;
  logic [SW-1:0]               side_r, side_nxt;
  logic [SW-1:0]               x_r, x_nxt;
  logic [SW-1:0]               z_r, z_nxt;
  logic [AW-1:0]               row_base_r, row_base_nxt;
  logic signed [TW-1:0]        row_t_r, row_t_nxt;
  logic signed [TW-1:0]        t_r, t_nxt;
  logic [AW-1:0]               iss_addr_r, iss_addr_nxt;
  logic                        iss_up_r, iss_up_nxt;
  logic signed [HEIGHT_W-1:0]  cell_r, cell_nxt;
  flha_out_t                   out_data_r, out_data_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [HEIGHT_W-1:0]         ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [HEIGHT_W-1:0]         ram_rdata;

  logic signed [HEIGHT_W-1:0]  h_old;
  logic signed [HEIGHT_W-1:0]  h_new;
  logic [AW-1:0]               fault_addr;
  logic [AW-1:0]               read_addr;
  logic [SW-1:0]               side_eff;
  logic                        t_pos;
  logic signed [TW-1:0]        row_step;

  flha_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign h_old      = ram_rdata;
  assign fault_addr = row_base_r + AW'(z_r);
  assign read_addr  = AW'(32'(cmd_r.cell_x) * GRID_SIDE + 32'(cmd_r.cell_z));
  assign side_eff   = (32'(active_side) > GRID_SIDE) ? SW'(GRID_SIDE) : SW'(active_side);
  assign t_pos      = !t_r[TW-1] && (t_r != '0);
  assign row_step   = row_t_r + TW'(cmd_r.dir_x);

  // saturating step of the cell under write-back
  always_comb begin
    if (iss_up_r) begin
      h_new = (h_old == HEIGHT_MAX) ? h_old : h_old + HEIGHT_ONE;
    end else begin
      h_new = (h_old == HEIGHT_MIN) ? h_old : h_old - HEIGHT_ONE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    wb_valid_nxt  = 1'b0;
    clr_addr_nxt  = clr_addr_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    cmd_nxt       = cmd_r;
    side_nxt      = side_r;
    x_nxt         = x_r;
    z_nxt         = z_r;
    row_base_nxt  = row_base_r;
    row_t_nxt     = row_t_r;
    t_nxt         = t_r;
    iss_addr_nxt  = iss_addr_r;
    iss_up_nxt    = iss_up_r;
    cell_nxt      = cell_r;
    out_data_nxt  = out_data_r;
    stat.pop      = 1'b0;
    stat.init_done = (state_r != S_INIT);
    ram_we        = 1'b0;
    ram_waddr     = iss_addr_r;
    ram_wdata     = h_new;
    ram_raddr     = fault_addr;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // write-back stage of the fault sweep
    if (wb_valid_r) begin
      ram_we = 1'b1;
      if (h_new > high_r) begin
        high_nxt = h_new;
      end
      if (h_new < low_r) begin
        low_nxt = h_new;
      end
    end

    case (state_r)
      S_INIT, S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          stat.pop     = 1'b1;
          cmd_nxt      = cmd;
          cell_nxt     = '0;
          side_nxt     = side_eff;
          x_nxt        = '0;
          z_nxt        = '0;
          row_base_nxt = '0;
          row_t_nxt    = -TW'(cmd.line_offset);
          t_nxt        = -TW'(cmd.line_offset);
          case (cmd.kind)
            CMD_CLEAR: begin
              high_nxt  = '0;
              low_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            CMD_FAULT: begin
              state_nxt = (side_eff == '0) ? S_DONE : S_FAULT;
            end
            CMD_READ: begin
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_FAULT: begin
        wb_valid_nxt = 1'b1;
        iss_addr_nxt = fault_addr;
        iss_up_nxt   = t_pos;
        if (z_r == side_r - SW'(1)) begin
          z_nxt = '0;
          if (x_r == side_r - SW'(1)) begin
            state_nxt = S_DRAIN;
          end else begin
            x_nxt        = x_r + SW'(1);
            row_base_nxt = row_base_r + AW'(GRID_SIDE);
            row_t_nxt    = row_step;
            t_nxt        = row_step;
          end
        end else begin
          z_nxt = z_r + SW'(1);
          t_nxt = t_r + TW'(cmd_r.dir_z);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_READ: begin
        ram_raddr = read_addr;
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        cell_nxt  = cmd_r.in_grid ? h_old : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.cell_height = cell_r;
          out_data_nxt.highest     = high_r;
          out_data_nxt.lowest      = low_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      wb_valid_r  <= 1'b0;
      clr_addr_r  <= '0;
      high_r      <= '0;
      low_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wb_valid_r  <= wb_valid_nxt;
      clr_addr_r  <= clr_addr_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    side_r     <= side_nxt;
    x_r        <= x_nxt;
    z_r        <= z_nxt;
    row_base_r <= row_base_nxt;
    row_t_r    <= row_t_nxt;
    t_r        <= t_nxt;
    iss_addr_r <= iss_addr_nxt;
    iss_up_r   <= iss_up_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_marks_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (high_r >= 0) && (low_r <= 0))
    else $error("height marks crossed zero");

  a_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    wb_valid_r |-> (state_r == S_FAULT || state_r == S_DRAIN))
    else $error("write-back outside fault sweep");

  a_sweep_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FAULT) |-> (x_r < side_r && z_r < side_r))
    else $error("fault sweep beyond active side");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");

endmodule
`default_nettype wire

### rtl/core/fault_line_heightmap_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fault_line_heightmap_accumulator
// Square heightmap built by repeated fault lines, with running high/low marks.
// ----------------------------------------------------------------------------
// fault item: one ram read-modify-write a cycle over the active side*side cells (none for a zero side)
// clear item: all GRID_SIDE*GRID_SIDE ram words zeroed, one ram word zeroed a cycle
// read items: one ram read, unused items: none; a two-entry queue takes items meanwhile
// after reset all GRID_SIDE*GRID_SIDE ram words are zeroed with in_ready low;
// configuration writes are taken throughout, active_side resets to 256
// ----------------------------------------------------------------------------
module fault_line_heightmap_accumulator
  import flha_pkg::*;
#(
  parameter int GRID_SIDE = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire flha_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output flha_out_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [SIDE_W-1:0] cfg_wdata
);

  logic [SIDE_W-1:0] active_side_r;
  logic              cmd_valid;
  flha_cmd_t         cmd;
  flha_stat_t        stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_side_r <= ACTIVE_SIDE_RESET;
    end else if (cfg_we) begin
      active_side_r <= cfg_wdata;
    end
  end

  flha_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  flha_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .active_side (active_side_r),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
